// ===== hw/rtl/flight_mode_sequencer_macros.svh =====
// assertion helpers for the flight mode sequencer
`ifndef FLIGHT_MODE_SEQUENCER_MACROS_SVH
`define FLIGHT_MODE_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
`define FMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FMS_ASSERT(lbl, prop, msg)
`define FMS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/fms_pkg.sv =====
package fms_pkg;

  localparam int YAW_NOW_W  = 10;
  localparam int PCT_W      = 7;
  localparam int YAW_REF_W  = 9;
  localparam int MODE_W     = 3;
  localparam int TAKEN_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_LANDED  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TAKEOFF = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FLYING  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LANDING = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SPIN    = 3'd4;

  // mode request codes
  localparam logic [MODE_W-1:0] REQ_FIRST = 3'd1;
  localparam logic [MODE_W-1:0] REQ_LAST  = 3'd5;

  // spin progress codes
  localparam logic [TAKEN_W-1:0] TAKEN_NONE  = 3'd0;
  localparam logic [TAKEN_W-1:0] TAKEN_ONE   = 3'd1;
  localparam logic [TAKEN_W-1:0] TAKEN_LAST  = 3'd3;
  localparam logic [TAKEN_W-1:0] TAKEN_LIMIT = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_RANGE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_FIRST_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_STEP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAKEOFF_ALTITUDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPINUP_MAIN_DUTY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPINUP_TAIL_DUTY = 3'd5;

  localparam logic [6:0] RST_SETTLE_RANGE     = 7'd10;
  localparam logic [8:0] RST_SPIN_FIRST_STEP  = 9'd75;
  localparam logic [8:0] RST_SPIN_STEP        = 9'd90;
  localparam logic [6:0] RST_TAKEOFF_ALTITUDE = 7'd10;
  localparam logic [6:0] RST_SPINUP_MAIN_DUTY = 7'd25;
  localparam logic [6:0] RST_SPINUP_TAIL_DUTY = 7'd5;

  typedef struct packed {
    logic signed [YAW_NOW_W-1:0] yaw_now;
    logic [PCT_W-1:0]            altitude_now;
    logic                        yaw_calibrated;
    logic                        alt_calibrated;
    logic [MODE_W-1:0]           mode_request;
    logic                        ref_write;
    logic [YAW_REF_W-1:0]        yaw_ref_value;
    logic [PCT_W-1:0]            alt_ref_value;
  } in_word_t;

  typedef struct packed {
    logic [MODE_W-1:0]    mode_out;
    logic [YAW_REF_W-1:0] yaw_ref_out;
    logic [PCT_W-1:0]     alt_ref_out;
    logic                 pid_enable;
    logic [PCT_W-1:0]     main_duty;
    logic [PCT_W-1:0]     tail_duty;
    logic                 clear_yaw_error;
    logic                 clear_calibration;
  } out_word_t;

  typedef struct packed {
    logic [6:0] settle_range;
    logic [8:0] spin_first_step;
    logic [8:0] spin_step;
    logic [6:0] takeoff_altitude;
    logic [6:0] spinup_main_duty;
    logic [6:0] spinup_tail_duty;
  } cfg_t;

  function automatic logic [PCT_W-1:0] sat100(input logic [PCT_W-1:0] v);
    return (v > PCT_MAX) ? PCT_MAX : v;
  endfunction

endpackage

// ===== hw/rtl/fms_cfg.sv =====
module fms_cfg
  import fms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_range     <= RST_SETTLE_RANGE;
      cfg_r.spin_first_step  <= RST_SPIN_FIRST_STEP;
      cfg_r.spin_step        <= RST_SPIN_STEP;
      cfg_r.takeoff_altitude <= RST_TAKEOFF_ALTITUDE;
      cfg_r.spinup_main_duty <= RST_SPINUP_MAIN_DUTY;
      cfg_r.spinup_tail_duty <= RST_SPINUP_TAIL_DUTY;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETTLE_RANGE:     cfg_r.settle_range     <= cfg_data[6:0];
        CFG_SPIN_FIRST_STEP:  cfg_r.spin_first_step  <= cfg_data;
        CFG_SPIN_STEP:        cfg_r.spin_step        <= cfg_data;
        CFG_TAKEOFF_ALTITUDE: cfg_r.takeoff_altitude <= cfg_data[6:0];
        CFG_SPINUP_MAIN_DUTY: cfg_r.spinup_main_duty <= cfg_data[6:0];
        CFG_SPINUP_TAIL_DUTY: cfg_r.spinup_tail_duty <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/fms_core.sv =====
module fms_core
  import fms_pkg::*;
#(
  parameter int FULL_TURN = 360
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  in_word_t  item,
  input  cfg_t      cfg,
  output out_word_t result
);

  localparam int REF_W = (FULL_TURN > 2) ? $clog2(FULL_TURN) : 1;
  localparam int SUM_W = ((REF_W > YAW_REF_W) ? REF_W : YAW_REF_W) + 1;
  localparam int SW    = ((REF_W > YAW_NOW_W) ? REF_W : YAW_NOW_W) + 2;
  // shifted turns needed to cover any SUM_W-bit operand
  localparam int MOD_STEPS = $clog2((2 ** SUM_W + FULL_TURN - 1) / FULL_TURN);

  // remainder by the full turn, restoring subtract of shifted turns
  function automatic logic [REF_W-1:0] mod_turn(input logic [SUM_W-1:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (r >= (32'(FULL_TURN) << k)) begin
        r = r - (32'(FULL_TURN) << k);
      end
    end
    return r[REF_W-1:0];
  endfunction

  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [REF_W-1:0]   yaw_ref_r, yaw_ref_nxt;
  logic [PCT_W-1:0]   alt_ref_r, alt_ref_nxt;
  logic [REF_W-1:0]   first_heading_r, first_heading_nxt;
  logic [TAKEN_W-1:0] taken_r, taken_nxt;
  logic               pid_r, pid_nxt;
  logic [PCT_W-1:0]   main_r, main_nxt;
  logic [PCT_W-1:0]   tail_r, tail_nxt;

  logic [MODE_W-1:0]  mode_w;
  logic [REF_W-1:0]   yaw_ref_w;
  logic [PCT_W-1:0]   alt_ref_w;
  logic [PCT_W-1:0]   target;
  logic signed [SW-1:0] yaw_s, ref_s, rng_s;
  logic               settled;
  logic               clr_yaw, clr_cal;

  always_comb begin
    mode_w    = mode_r;
    yaw_ref_w = yaw_ref_r;
    alt_ref_w = alt_ref_r;
    if (item.mode_request inside {[REQ_FIRST:REQ_LAST]}) begin
      mode_w = 3'(item.mode_request - REQ_FIRST);
    end
    if (item.ref_write) begin
      yaw_ref_w = mod_turn(SUM_W'(item.yaw_ref_value));
      alt_ref_w = sat100(item.alt_ref_value);
    end

    // settled window, no wrap
    yaw_s   = SW'(item.yaw_now);
    ref_s   = $signed(SW'(yaw_ref_w));
    rng_s   = $signed(SW'(cfg.settle_range));
    settled = (yaw_s > ref_s - rng_s) && (yaw_s < ref_s + rng_s);
    target  = sat100(cfg.takeoff_altitude);

    mode_nxt          = mode_w;
    yaw_ref_nxt       = yaw_ref_w;
    alt_ref_nxt       = alt_ref_w;
    first_heading_nxt = first_heading_r;
    taken_nxt         = taken_r;
    pid_nxt           = pid_r;
    main_nxt          = main_r;
    tail_nxt          = tail_r;
    clr_yaw           = 1'b0;
    clr_cal           = 1'b0;

    case (mode_w)
      MODE_TAKEOFF: begin
        if (item.altitude_now >= target) begin
          mode_nxt    = MODE_FLYING;
          yaw_ref_nxt = '0;
        end else if (item.yaw_calibrated && item.alt_calibrated) begin
          pid_nxt     = 1'b1;
          alt_ref_nxt = target;
          yaw_ref_nxt = '0;
        end else begin
          pid_nxt  = 1'b0;
          main_nxt = sat100(cfg.spinup_main_duty);
          tail_nxt = sat100(cfg.spinup_tail_duty);
        end
      end
      MODE_LANDING: begin
        if (item.altitude_now == '0 && item.yaw_now == '0) begin
          mode_nxt = MODE_LANDED;
          pid_nxt  = 1'b0;
          main_nxt = '0;
          tail_nxt = '0;
        end else begin
          alt_ref_nxt = '0;
          yaw_ref_nxt = '0;
        end
      end
      MODE_FLYING: begin
        pid_nxt = 1'b1;
      end
      MODE_LANDED: begin
        clr_cal  = 1'b1;
        pid_nxt  = 1'b0;
        main_nxt = '0;
        tail_nxt = '0;
      end
      MODE_SPIN: begin
        if (taken_r == TAKEN_NONE) begin
          first_heading_nxt = yaw_ref_w;
          yaw_ref_nxt = mod_turn(SUM_W'(yaw_ref_w) + SUM_W'(cfg.spin_first_step));
          taken_nxt   = TAKEN_ONE;
        end else if (first_heading_r == yaw_ref_w && settled) begin
          clr_yaw   = 1'b1;
          mode_nxt  = MODE_FLYING;
          taken_nxt = TAKEN_NONE;
        end else if (taken_r == TAKEN_LAST && settled) begin
          yaw_ref_nxt = first_heading_r;
        end else if (taken_r < TAKEN_LIMIT && settled) begin
          yaw_ref_nxt = mod_turn(SUM_W'(yaw_ref_w) + SUM_W'(cfg.spin_step));
          taken_nxt   = taken_r + TAKEN_ONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_LANDED;
      yaw_ref_r       <= '0;
      alt_ref_r       <= '0;
      first_heading_r <= '0;
      taken_r         <= TAKEN_NONE;
      pid_r           <= 1'b0;
      main_r          <= '0;
      tail_r          <= '0;
    end else if (adv) begin
      mode_r          <= mode_nxt;
      yaw_ref_r       <= yaw_ref_nxt;
      alt_ref_r       <= alt_ref_nxt;
      first_heading_r <= first_heading_nxt;
      taken_r         <= taken_nxt;
      pid_r           <= pid_nxt;
      main_r          <= main_nxt;
      tail_r          <= tail_nxt;
    end
  end

  always_comb begin
    result.mode_out          = mode_nxt;
    result.yaw_ref_out       = YAW_REF_W'(yaw_ref_nxt);
    result.alt_ref_out       = alt_ref_nxt;
    result.pid_enable        = pid_nxt;
    result.main_duty         = main_nxt;
    result.tail_duty         = tail_nxt;
    result.clear_yaw_error   = clr_yaw;
    result.clear_calibration = clr_cal;
  end

endmodule

// ===== hw/rtl/flight_mode_sequencer.sv =====
// flight mode sequencer
// in_* carries one sequencer tick per word: measured yaw and altitude, the
// calibration flags, an optional mode request and an optional reference write.
// out_* returns one word per tick: mode, references, controller enable, rotor
// override duties and the two clear pulses, showing the state after the tick.
// cfg_* writes the six tuning registers by index; write only while idle.
// Both streaming channels are valid/ready. A word is registered on accept,
// passes the mode update logic and lands in the output register, which
// raises out_valid. Throughput is one word per cycle while the output is
// taken, set by the single registered pass through the mode update logic.
// When out_ready is low the output register holds its word and the input
// register still takes one more word; then in_ready drops until the result
// moves on. Synchronous active-low reset empties both registers, puts the
// sequencer in landed mode with zero references and motors off, and loads
// the default tuning values.
`include "flight_mode_sequencer_macros.svh"

module flight_mode_sequencer
  import fms_pkg::*;
#(
  parameter int FULL_TURN = 360
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  in_word_t  item_r;
  logic      s1_valid_r;
  out_word_t out_data_r;
  logic      out_valid_r;
  out_word_t result;
  logic      adv;

  fms_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fms_core #(
    .FULL_TURN (FULL_TURN)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FMS_ASSERT(a_clr_cal_landed, out_valid_r && out_data_r.clear_calibration |-> out_data_r.mode_out == MODE_LANDED, "calibration clear outside landed mode")
  `FMS_ASSERT(a_clr_yaw_flying, out_valid_r && out_data_r.clear_yaw_error |-> out_data_r.mode_out == MODE_FLYING, "yaw clear without return to flying")
  `FMS_ASSERT(a_landed_motors_off, out_valid_r && out_data_r.mode_out == MODE_LANDED |-> !out_data_r.pid_enable && out_data_r.main_duty == '0 && out_data_r.tail_duty == '0, "motors active while landed")
  `FMS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !s1_valid_r && !out_valid_r, "pipeline not empty after reset")

endmodule
